/* rtl/core/graph_connectivity_table_macros.svh */
// ----------------------------------------------------------------------------
// Graph connectivity table assertion macros
// Shared concurrent assertion forms for the graph connectivity table RTL.
// ----------------------------------------------------------------------------
`ifndef GRAPH_CONNECTIVITY_TABLE_MACROS_SVH
`define GRAPH_CONNECTIVITY_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// The condition must never be true out of reset.
`define GCT_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("gct: forbidden condition observed");
// The consequent must hold in the same cycle as the antecedent.
`define GCT_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("gct: same-cycle implication failed");
// The consequent must hold in the cycle after the antecedent.
`define GCT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("gct: next-cycle implication failed");
`else
`define GCT_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`define GCT_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define GCT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

/* rtl/core/gct_pkg.sv */
// ----------------------------------------------------------------------------
// Graph connectivity table package
// Sizes, request and status codes, controller states and shared helpers.
// ----------------------------------------------------------------------------
package gct_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int SLOT_W       = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
  localparam int CNT_W        = 5;
  localparam int CNT_MAX      = 31;
  localparam int ID_W         = 32;
  localparam int REQ_W        = 3;
  localparam int STAT_W       = 3;
  localparam int IN_TDATA_W   = 2 * ID_W;
  localparam int IN_TUSER_W   = REQ_W;
  localparam int OUT_TDATA_W  = 16;
  localparam int OUT_PAD_W    = OUT_TDATA_W - (STAT_W + 2 * CNT_W + 1);

  typedef logic [MAX_VERTICES-1:0] vmask_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_VERTEX = 3'd0,
    REQ_DEL_VERTEX = 3'd1,
    REQ_INS_EDGE   = 3'd2,
    REQ_DEL_EDGE   = 3'd3,
    REQ_SEARCH     = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK           = 3'd0,
    STAT_EXISTS       = 3'd1,
    STAT_MISSING      = 3'd2,
    STAT_EDGE_EXISTS  = 3'd3,
    STAT_EDGE_MISSING = 3'd4,
    STAT_FULL         = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC,
    S_SEARCH,
    S_RESP
  } gct_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_req;
    logic lookup;
    logic exec;
    logic step;
    logic load_out;
  } gct_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic search_go;
  } gct_sts_t;

  // Population count of a vertex mask, saturated to the result field.
  function automatic logic [CNT_W-1:0] popcount(vmask_t m);
    logic [VCNT_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      sum = sum + VCNT_W'(m[i]);
    end
    if (int'(sum) > CNT_MAX) begin
      return CNT_W'(CNT_MAX);
    end
    return CNT_W'(sum);
  endfunction

endpackage

/* rtl/core/graph_connectivity_table.sv */
// ----------------------------------------------------------------------------
// Graph connectivity table
// Undirected graph store with vertex and edge updates and a reach search.
// ----------------------------------------------------------------------------
// The block keeps an undirected graph of up to MAX_VERTICES vertices, each
// named by a 32-bit identifier, and answers every request transfer with
// exactly one result transfer. A request inserts or removes a vertex (removal
// also drops its edges), inserts or removes an edge, or searches from a start
// vertex; the result carries a status code, the reached count, the number of
// stored vertices and a connected flag. Requests are handled one at a time:
// an update goes through the input transfer, the identifier lookup, the
// table update and the result load into the output register, and a search
// makes MAX_VERTICES reach passes between the table update and the result
// load, since the reach set grows by one pass over the adjacency matrix per
// clock. The next request is taken as soon as the result sits in the output
// register, even if the downstream side has not yet taken it; a result only
// waits in its last step when the output register still holds the previous
// result. No clearing pass is needed after reset.
module graph_connectivity_table
  import gct_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Request channel.
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,   // [31:0] vertex_a, [63:32] vertex_b
  input  logic [IN_TUSER_W-1:0]   in_tuser,   // [2:0] req_type
  // Result channel.
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [2:0] status, [7:3] reached_count, [12:8] total_count, [13] is_connected,
  // [15:14] zero
  output logic [OUT_TDATA_W-1:0]  out_tdata
);

  gct_cmd_t cmd;
  gct_sts_t sts;

  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  reached_count;
  logic [CNT_W-1:0]  total_count;
  logic              is_connected;

  // The controller steps each request through its phases.
  gct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath holds the graph and the registered result fields.
  gct_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_tuser[REQ_W-1:0]),
    .in_vertex_a       (signed'(in_tdata[ID_W-1:0])),
    .in_vertex_b       (signed'(in_tdata[2*ID_W-1:ID_W])),
    .out_status        (status),
    .out_reached_count (reached_count),
    .out_total_count   (total_count),
    .out_is_connected  (is_connected)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, is_connected, total_count, reached_count, status};

endmodule

/* rtl/core/gct_ctrl.sv */
// ----------------------------------------------------------------------------
// Graph connectivity table controller
// Sequences lookup, update, reach passes and result handoff for each request.
// ----------------------------------------------------------------------------
`include "graph_connectivity_table_macros.svh"

module gct_ctrl
  import gct_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  gct_sts_t  sts,
  output gct_cmd_t  cmd
);

  localparam logic [SLOT_W-1:0] PASS_LAST = SLOT_W'(MAX_VERTICES - 1);

  gct_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] pass_cnt_r, pass_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_LOOKUP;
      S_LOOKUP: state_nxt = S_EXEC;
      S_EXEC:   state_nxt = sts.search_go ? S_SEARCH : S_RESP;
      S_SEARCH: if (pass_cnt_r == PASS_LAST) state_nxt = S_RESP;
      S_RESP:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_req = in_tvalid;
      end
      S_LOOKUP: cmd.lookup   = 1'b1;
      S_EXEC:   cmd.exec     = 1'b1;
      S_SEARCH: cmd.step     = 1'b1;
      S_RESP:   cmd.load_out = out_free;
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    pass_cnt_nxt = pass_cnt_r;
    if (cmd.exec) begin
      pass_cnt_nxt = '0;
    end else if (cmd.step) begin
      pass_cnt_nxt = pass_cnt_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_cnt_r  <= pass_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `GCT_ASSERT_NEXT(a_search_exit, clk, rst_n,
    state_r == S_SEARCH && pass_cnt_r == PASS_LAST, state_r == S_RESP)
  `GCT_ASSERT_IMPL(a_no_overwrite, clk, rst_n,
    out_valid_r && !out_tready, !cmd.load_out)
  `GCT_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, cmd.load_out,
    out_tvalid && state_r == S_IDLE)

endmodule

/* rtl/core/gct_dp.sv */
// ----------------------------------------------------------------------------
// Graph connectivity table datapath
// Vertex table, adjacency matrix, identifier lookup, reach set and result.
// ----------------------------------------------------------------------------
`include "graph_connectivity_table_macros.svh"

module gct_dp
  import gct_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  gct_cmd_t                cmd,
  output gct_sts_t                sts,
  input  logic [REQ_W-1:0]        in_req_type,
  input  logic signed [ID_W-1:0]  in_vertex_a,
  input  logic signed [ID_W-1:0]  in_vertex_b,
  output logic [STAT_W-1:0]       out_status,
  output logic [CNT_W-1:0]        out_reached_count,
  output logic [CNT_W-1:0]        out_total_count,
  output logic                    out_is_connected
);

  // Latched request.
  logic [REQ_W-1:0]  req_r;
  logic [ID_W-1:0]   ida_r, idb_r;

  // Lookup results.
  logic              hit_a_r, hit_b_r, free_ok_r;
  logic [SLOT_W-1:0] sa_r, sb_r, free_r;
  logic              hit_a_nxt, hit_b_nxt, free_ok_nxt;
  logic [SLOT_W-1:0] sa_nxt, sb_nxt, free_nxt;

  // Graph storage.
  vmask_t            valid_r, valid_nxt;
  logic [ID_W-1:0]   ident_r [MAX_VERTICES];
  vmask_t            adj_r [MAX_VERTICES];
  vmask_t            adj_nxt [MAX_VERTICES];
  logic              ident_we;

  // Search and result.
  vmask_t            reach_r, reach_nxt;
  logic              search_ok_r;
  logic [STAT_W-1:0] status_r, status_nxt;

  // Parallel identifier compare and lowest free slot.
  always_comb begin
    hit_a_nxt   = 1'b0;
    hit_b_nxt   = 1'b0;
    sa_nxt      = '0;
    sb_nxt      = '0;
    free_ok_nxt = 1'b0;
    free_nxt    = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (valid_r[i] && ident_r[i] == ida_r) begin
        hit_a_nxt = 1'b1;
        sa_nxt    = sa_nxt | SLOT_W'(i);
      end
      if (valid_r[i] && ident_r[i] == idb_r) begin
        hit_b_nxt = 1'b1;
        sb_nxt    = sb_nxt | SLOT_W'(i);
      end
    end
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_ok_nxt = 1'b1;
        free_nxt    = SLOT_W'(i);
      end
    end
  end

  // Table update for the latched request.
  always_comb begin
    logic present;
    present    = adj_r[sa_r][sb_r];
    valid_nxt  = valid_r;
    adj_nxt    = adj_r;
    ident_we   = 1'b0;
    status_nxt = STAT_OK;
    unique case (req_r)
      REQ_INS_VERTEX: begin
        if (hit_a_r) begin
          status_nxt = STAT_EXISTS;
        end else if (!free_ok_r) begin
          status_nxt = STAT_FULL;
        end else begin
          ident_we         = 1'b1;
          valid_nxt[free_r] = 1'b1;
          adj_nxt[free_r]  = '0;
          for (int i = 0; i < MAX_VERTICES; i++) begin
            adj_nxt[i][free_r] = 1'b0;
          end
        end
      end
      REQ_DEL_VERTEX: begin
        if (!hit_a_r) begin
          status_nxt = STAT_MISSING;
        end else begin
          valid_nxt[sa_r] = 1'b0;
          adj_nxt[sa_r]   = '0;
          for (int i = 0; i < MAX_VERTICES; i++) begin
            adj_nxt[i][sa_r] = 1'b0;
          end
        end
      end
      REQ_INS_EDGE: begin
        if (!hit_a_r || !hit_b_r) begin
          status_nxt = STAT_MISSING;
        end else if (present) begin
          status_nxt = STAT_EDGE_EXISTS;
        end else begin
          adj_nxt[sa_r][sb_r] = 1'b1;
          adj_nxt[sb_r][sa_r] = 1'b1;
        end
      end
      REQ_DEL_EDGE: begin
        if (!hit_a_r || !hit_b_r) begin
          status_nxt = STAT_MISSING;
        end else if (!present) begin
          status_nxt = STAT_EDGE_MISSING;
        end else begin
          adj_nxt[sa_r][sb_r] = 1'b0;
          adj_nxt[sb_r][sa_r] = 1'b0;
        end
      end
      REQ_SEARCH: begin
        if (!hit_a_r) begin
          status_nxt = STAT_MISSING;
        end
      end
      default: status_nxt = STAT_OK;
    endcase
  end

  assign sts.search_go = (req_r == REQ_SEARCH) && hit_a_r;

  // One reach pass: every reached vertex adds its neighbors; exec seeds the start vertex.
  always_comb begin
    reach_nxt = reach_r;
    if (cmd.exec) begin
      reach_nxt = vmask_t'(1) << sa_r;
    end else begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        if (reach_r[i]) begin
          reach_nxt = reach_nxt | adj_r[i];
        end
      end
      reach_nxt = reach_nxt & valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_req_type;
      ida_r <= unsigned'(in_vertex_a);
      idb_r <= unsigned'(in_vertex_b);
    end
    if (cmd.lookup) begin
      hit_a_r   <= hit_a_nxt;
      hit_b_r   <= hit_b_nxt;
      sa_r      <= sa_nxt;
      sb_r      <= sb_nxt;
      free_ok_r <= free_ok_nxt;
      free_r    <= free_nxt;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
    end
    if (cmd.exec || cmd.step) begin
      reach_r <= reach_nxt;
    end
    if (cmd.exec && ident_we) begin
      ident_r[free_r] <= ida_r;
    end
    if (cmd.load_out) begin
      out_status        <= status_r;
      out_reached_count <= search_ok_r ? popcount(reach_r) : '0;
      out_total_count   <= popcount(valid_r);
      out_is_connected  <= search_ok_r && (reach_r == valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      search_ok_r <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      valid_r     <= valid_nxt;
      search_ok_r <= sts.search_go;
      adj_r       <= adj_nxt;
    end
  end

  // Invariant checks on the stored graph.
  logic adj_asym, adj_orphan;

  always_comb begin
    adj_asym   = 1'b0;
    adj_orphan = 1'b0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (!valid_r[i] && adj_r[i] != '0) begin
        adj_orphan = 1'b1;
      end
      for (int j = 0; j < MAX_VERTICES; j++) begin
        if (adj_r[i][j] != adj_r[j][i]) begin
          adj_asym = 1'b1;
        end
      end
    end
  end

  `GCT_ASSERT_NEVER(a_adj_symmetric, clk, rst_n, adj_asym)
  `GCT_ASSERT_NEVER(a_adj_no_orphan, clk, rst_n, adj_orphan)
  `GCT_ASSERT_NEVER(a_reach_in_graph, clk, rst_n,
    search_ok_r && ((reach_r & ~valid_r) != '0))

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph connectivity table testbench
// Drives vertex, edge and search requests into the graph store and checks
// every result against a cycle-free behavioral copy of the graph held here.
// ----------------------------------------------------------------------------
module tb
  import gct_pkg::*;
();

  // One request as it travels on the input stream.
  typedef struct packed {
    req_t        kind;
    logic [31:0] id_a;
    logic [31:0] id_b;
  } graph_req_t;

  // One result as the block reports it.
  typedef struct packed {
    status_t     status;
    logic [4:0]  reached;
    logic [4:0]  total;
    logic        connected;
  } graph_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [31:0] vertex_a, [63:32] vertex_b
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // [2:0] req_type
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [2:0] status, [7:3] reached_count, [12:8] total_count, [13] is_connected
  logic [OUT_TDATA_W-1:0] out_tdata;

  graph_connectivity_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Stimulus waiting for the driver, and results predicted for transfers that
  // the block has already accepted, oldest first.
  graph_req_t    pending_reqs[$];
  graph_result_t expected_results[$];
  graph_req_t    req_on_bus;

  // Percentages of cycles in which each side holds back.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int mismatches = 0;
  int results_seen = 0;
  int searches = 0;
  int connected_searches = 0;
  int status_hits[8];

  // Shadow copy of the graph: which slots hold a vertex, their identifiers and
  // one adjacency row per slot.
  vmask_t      slot_used = '0;
  logic [31:0] slot_id [MAX_VERTICES];
  vmask_t      adj_row [MAX_VERTICES];

  // Identifier pool for the random part. The first four are the signed and
  // unsigned 32-bit extremes, so every identifier bit is exercised both ways.
  logic [31:0] id_pool [20];

  // --------------------------------------------------------------------------
  // Graph predictor
  // --------------------------------------------------------------------------
  function automatic int locate_vertex(logic [31:0] id);
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (slot_used[i] && slot_id[i] == id) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic logic [4:0] vertex_tally(vmask_t m);
    int n;
    n = $countones(m);
    return (n > 31) ? 5'd31 : n[4:0];
  endfunction

  // Applies one request to the shadow graph and returns the result the block
  // has to report for it.
  function automatic graph_result_t apply_request(graph_req_t r);
    graph_result_t res;
    int            sa;
    int            sb;
    int            free_slot;
    vmask_t        reach;
    vmask_t        grown;
    res = '{status: STAT_OK, reached: '0, total: '0, connected: 1'b0};
    case (r.kind)
      REQ_INS_VERTEX: begin
        // A duplicate identifier is rejected before the table is checked
        // for room.
        if (locate_vertex(r.id_a) >= 0) begin
          res.status = STAT_EXISTS;
        end else begin
          free_slot = -1;
          for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (!slot_used[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            res.status = STAT_FULL;
          end else begin
            slot_used[free_slot] = 1'b1;
            slot_id[free_slot]   = r.id_a;
            adj_row[free_slot]   = '0;
            for (int i = 0; i < MAX_VERTICES; i++) adj_row[i][free_slot] = 1'b0;
          end
        end
      end
      REQ_DEL_VERTEX: begin
        sa = locate_vertex(r.id_a);
        if (sa < 0) begin
          res.status = STAT_MISSING;
        end else begin
          slot_used[sa] = 1'b0;
          adj_row[sa]   = '0;
          for (int i = 0; i < MAX_VERTICES; i++) adj_row[i][sa] = 1'b0;
        end
      end
      REQ_INS_EDGE, REQ_DEL_EDGE: begin
        sa = locate_vertex(r.id_a);
        sb = locate_vertex(r.id_b);
        if (sa < 0 || sb < 0) begin
          res.status = STAT_MISSING;
        end else if (r.kind == REQ_INS_EDGE) begin
          if (adj_row[sa][sb]) begin
            res.status = STAT_EDGE_EXISTS;
          end else begin
            adj_row[sa][sb] = 1'b1;
            adj_row[sb][sa] = 1'b1;
          end
        end else begin
          if (!adj_row[sa][sb]) begin
            res.status = STAT_EDGE_MISSING;
          end else begin
            adj_row[sa][sb] = 1'b0;
            adj_row[sb][sa] = 1'b0;
          end
        end
      end
      REQ_SEARCH: begin
        searches++;
        sa = locate_vertex(r.id_a);
        if (sa < 0) begin
          res.status = STAT_MISSING;
        end else begin
          // Grow the reached set one hop per pass; MAX_VERTICES passes reach
          // every vertex of the component.
          reach = '0;
          reach[sa] = 1'b1;
          for (int pass = 0; pass < MAX_VERTICES; pass++) begin
            grown = reach;
            for (int i = 0; i < MAX_VERTICES; i++) begin
              if (reach[i]) grown |= adj_row[i];
            end
            reach = grown & slot_used;
          end
          res.reached   = vertex_tally(reach);
          res.connected = (reach == slot_used);
          if (res.connected) connected_searches++;
        end
      end
      default: res.status = STAT_OK;
    endcase
    res.total = vertex_tally(slot_used);
    status_hits[res.status]++;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: a new transfer is offered only once the previous one has
  // been taken, and the valid is held steady while the block stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_request(req_on_bus));
      end
      if (!(in_tvalid && !in_tready)) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_on_bus = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {req_on_bus.id_b, req_on_bus.id_a};
          in_tuser  <= req_on_bus.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: every accepted result transfer is matched against the
  // oldest prediction. The two top bits of the result word must stay zero.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    graph_result_t          want;
    logic [OUT_TDATA_W-1:0] want_word;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%t: result transfer with nothing pending, tdata=%h", $realtime,
                     out_tdata);
          end
        end else begin
          want = expected_results.pop_front();
          want_word = {2'b00, want.connected, want.total, want.reached, want.status};
          if (out_tdata !== want_word) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t: result mismatch", $realtime);
              $display("  expected status=%0d reached=%0d total=%0d connected=%0d",
                       want.status, want.reached, want.total, want.connected);
              $display("  actual   status=%0d reached=%0d total=%0d connected=%0d pad=%b",
                       out_tdata[2:0], out_tdata[7:3], out_tdata[12:8], out_tdata[13],
                       out_tdata[15:14]);
            end
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_req(req_t kind, logic [31:0] a, logic [31:0] b);
    pending_reqs.push_back('{kind: kind, id_a: a, id_b: b});
  endtask

  // Mostly identifiers from the first span entries of the pool, so that edges
  // land on stored vertices; now and then a stray identifier.
  function automatic logic [31:0] pick_id(int span);
    if ($urandom_range(19) == 0) begin
      return $urandom;
    end
    return id_pool[$urandom_range(span - 1)];
  endfunction

  // One episode of related requests: fill the table past capacity, empty it,
  // or work on a graph over a prefix of random length of the pool.
  task automatic queue_episode();
    int          mode;
    int          span;
    int          count;
    int          order [20];
    int          j;
    int          tmp;
    int          roll;
    logic [31:0] a;
    mode = $urandom_range(99);
    for (int i = 0; i < 20; i++) order[i] = i;
    for (int i = 19; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    if (mode < 15) begin
      // Twenty distinct identifiers into sixteen slots: the tail is refused.
      for (int i = 0; i < 20; i++) begin
        queue_req(REQ_INS_VERTEX, id_pool[order[i]], $urandom);
        if ($urandom_range(3) == 0) begin
          queue_req(REQ_SEARCH, id_pool[order[$urandom_range(i)]], $urandom);
        end
      end
    end else if (mode < 25) begin
      // Drain the pool identifiers from the table, then search what remains.
      for (int i = 0; i < 20; i++) begin
        queue_req(REQ_DEL_VERTEX, id_pool[order[i]], $urandom);
      end
      queue_req(REQ_SEARCH, pick_id(20), $urandom);
    end else begin
      span  = $urandom_range(2, 20);
      count = $urandom_range(20, 40);
      for (int i = 0; i < count; i++) begin
        roll = $urandom_range(99);
        a = pick_id(span);
        if (roll < 25) begin
          queue_req(REQ_INS_VERTEX, a, $urandom);
        end else if (roll < 35) begin
          queue_req(REQ_DEL_VERTEX, a, $urandom);
        end else if (roll < 65) begin
          queue_req(REQ_INS_EDGE, a, pick_id(span));
        end else if (roll < 80) begin
          queue_req(REQ_DEL_EDGE, a, pick_id(span));
        end else begin
          queue_req(REQ_SEARCH, a, $urandom);
        end
      end
    end
  endtask

  task automatic drain_phase();
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'h7FFF_FFFF;
    id_pool[2] = 32'h8000_0000;
    id_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 20; i++) id_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase one: the sender rarely pauses, the receiver stalls most cycles.
    send_idle_pct = 6;
    recv_idle_pct = 60;

    // Directed opening: empty-graph search, identifier extremes, duplicate
    // vertex, self-loop, duplicate and absent edges, missing origin and
    // destination, removal dropping edges, and reuse of a freed slot.
    queue_req(REQ_SEARCH,     32'h0000_0000, $urandom);
    queue_req(REQ_INS_VERTEX, 32'h0000_0000, $urandom);
    queue_req(REQ_INS_VERTEX, 32'h7FFF_FFFF, $urandom);
    queue_req(REQ_INS_VERTEX, 32'h8000_0000, $urandom);
    queue_req(REQ_INS_VERTEX, 32'hFFFF_FFFF, $urandom);
    queue_req(REQ_INS_VERTEX, 32'h0000_0000, $urandom);
    queue_req(REQ_INS_EDGE,   32'h0000_0000, 32'h0000_0000);
    queue_req(REQ_INS_EDGE,   32'h0000_0000, 32'h7FFF_FFFF);
    queue_req(REQ_INS_EDGE,   32'h7FFF_FFFF, 32'h0000_0000);
    queue_req(REQ_INS_EDGE,   32'h0000_0000, 32'h1234_5678);
    queue_req(REQ_INS_EDGE,   32'h1234_5678, 32'h0000_0000);
    queue_req(REQ_SEARCH,     32'h0000_0000, $urandom);
    queue_req(REQ_INS_EDGE,   32'h8000_0000, 32'hFFFF_FFFF);
    queue_req(REQ_INS_EDGE,   32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(REQ_SEARCH,     32'hFFFF_FFFF, $urandom);
    queue_req(REQ_DEL_EDGE,   32'h0000_0000, 32'hFFFF_FFFF);
    queue_req(REQ_DEL_EDGE,   32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(REQ_DEL_EDGE,   32'h0000_0000, 32'h0000_0000);
    queue_req(REQ_SEARCH,     32'h0000_0000, $urandom);
    queue_req(REQ_DEL_VERTEX, 32'h1234_5678, $urandom);
    queue_req(REQ_DEL_VERTEX, 32'h7FFF_FFFF, $urandom);
    queue_req(REQ_SEARCH,     32'h0000_0000, $urandom);
    queue_req(REQ_SEARCH,     32'h1234_5678, $urandom);
    queue_req(REQ_INS_VERTEX, 32'h7FFF_FFFF, $urandom);
    queue_req(REQ_SEARCH,     32'h7FFF_FFFF, $urandom);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 60;
        recv_idle_pct = 6;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      while (pending_reqs.size() < 670) queue_episode();
      drain_phase();
    end

    // Every prediction has been matched by now; let the block settle before the report.
    repeat (40) @(negedge clk);

    $display("Checked %0d results: %0d searches (%0d connected), %0d full-table refusals,",
             results_seen, searches, connected_searches, status_hits[STAT_FULL]);
    $display("%0d missing-vertex and %0d duplicate-vertex refusals, %0d mismatches.",
             status_hits[STAT_MISSING], status_hits[STAT_EXISTS], mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[graph_connectivity_table] OK");
    end else begin
      $display("[graph_connectivity_table] ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("[graph_connectivity_table] ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/gct_pkg.sv
rtl/core/gct_ctrl.sv
rtl/core/gct_dp.sv
rtl/core/graph_connectivity_table.sv
tb/sv/tb.sv
